>>> rtl/core/sbcq_pkg.sv
package sbcq_pkg;

   localparam int Q_W        = 32;
   localparam int DIFF_W     = 35;
   localparam int DIV_STEPS  = 33;
   localparam int DIV_PER    = 2;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
   localparam int DIV_LAT    = DIV_STAGES + 2;
   localparam int REQ_W      = 216;
   localparam int RSP_W      = 112;

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic valid;
      logic consider;
      logic last;
   } slot_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [30:0]        hw;
      logic [30:0]        hh;
      logic [7:0]         layer;
   } entry_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] t;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [1:0]  nx;
      logic signed [1:0]  ny;
   } hit_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(Q_MAX)) r = Q_MAX;
      else if (v < 64'(Q_MIN)) r = Q_MIN;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [1:0] sgn2(input logic signed [32:0] v);
      logic signed [1:0] r;
      if (v > 0) r = 2'sd1;
      else if (v < 0) r = -2'sd1;
      else r = 2'sd0;
      return r;
   endfunction

endpackage

>>> rtl/core/sbcq_table.sv
module sbcq_table #(
   parameter int MAX_BOXES = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] wr_addr,
   input  sbcq_pkg::entry_type                   wr_data,
   input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] rd_addr,
   output sbcq_pkg::entry_type                   rd_data
);
   import sbcq_pkg::*;

   entry_type mem_ff [MAX_BOXES];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

>>> rtl/core/sbcq_div.sv
module sbcq_div (
   input  logic               clock,
   input  logic signed [63:0] num_i,
   input  logic signed [31:0] den_i,
   output logic signed [31:0] q_o
);
   import sbcq_pkg::*;

   logic [63:0] r_ff [DIV_STAGES+1];
   logic [63:0] r_in [DIV_STAGES+1];
   logic [32:0] q_ff [DIV_STAGES+1];
   logic [32:0] q_in [DIV_STAGES+1];
   logic [31:0] d_ff [DIV_STAGES+1];
   logic        neg_ff [DIV_STAGES+1];
   logic        ovf_ff [DIV_STAGES+1];
   logic signed [31:0] q_out_ff;
   logic signed [31:0] q_out_in;

   logic [63:0] nmag;
   logic [31:0] dmag;
   logic        ovf0;

   always_comb begin
      nmag = num_i[63] ? 64'(-num_i) : 64'(num_i);
      dmag = den_i[31] ? 32'(-den_i) : 32'(den_i);
      ovf0 = {1'b0, nmag} >= (65'(dmag) << DIV_STEPS);
   end

   always_comb begin
      logic [63:0] r;
      logic [32:0] q;
      logic [63:0] sub;
      int k;
      r_in[0] = nmag;
      q_in[0] = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = r_ff[s];
         q = q_ff[s];
         for (int j = 0; j < DIV_PER; j++) begin
            k = DIV_STEPS - 1 - (s * DIV_PER + j);
            if (k >= 0) begin
               sub = 64'(d_ff[s]) << k;
               if (r >= sub) begin
                  r = r - sub;
                  q = q | (33'(1) << k);
               end
            end
         end
         r_in[s+1] = r;
         q_in[s+1] = q;
      end
   end

   always_comb begin
      logic [32:0] qm;
      qm = q_ff[DIV_STAGES];
      if (neg_ff[DIV_STAGES]) begin
         if (ovf_ff[DIV_STAGES] || qm > 33'h0_8000_0000) q_out_in = Q_MIN;
         else q_out_in = 32'(-qm);
      end else begin
         if (ovf_ff[DIV_STAGES] || qm > 33'h0_7FFF_FFFF) q_out_in = Q_MAX;
         else q_out_in = qm[31:0];
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= r_in[0];
      q_ff[0]   <= q_in[0];
      d_ff[0]   <= dmag;
      neg_ff[0] <= num_i[63] ^ den_i[31];
      ovf_ff[0] <= ovf0;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         r_ff[s]   <= r_in[s];
         q_ff[s]   <= q_in[s];
         d_ff[s]   <= d_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
      end
      q_out_ff <= q_out_in;
   end

   assign q_o = q_out_ff;

endmodule

>>> rtl/core/sbcq_tester.sv
module sbcq_tester #(
   parameter int MAX_BOXES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  sbcq_pkg::slot_type  slot_i,
   input  logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] idx_i,
   input  sbcq_pkg::entry_type entry_i,
   input  logic signed [31:0]  px_i,
   input  logic signed [31:0]  py_i,
   input  logic [30:0]         hx_i,
   input  logic [30:0]         hy_i,
   input  logic signed [31:0]  mx_i,
   input  logic signed [31:0]  my_i,
   input  logic [7:0]          mask_i,
   output sbcq_pkg::slot_type  slot_o,
   output logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] idx_o,
   output sbcq_pkg::hit_type   hit_o
);
   import sbcq_pkg::*;

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      slot_type           slot;
      logic               zfail;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [31:0]        ghx;
      logic [31:0]        ghy;
      logic [IDX_W-1:0]   idx;
   } side_type;

   // stage 0: grown box, slab offsets
   side_type                  s0_ff, s0_in;
   logic signed [DIFF_W-1:0]  dlx_ff, dhx_ff, dly_ff, dhy_ff;
   logic signed [DIFF_W-1:0]  dlx_in, dhx_in, dly_in, dhy_in;

   always_comb begin
      logic signed [33:0] lox, hix, loy, hiy;
      logic               inx, iny;
      s0_in.ghx = {1'b0, entry_i.hw} + {1'b0, hx_i};
      s0_in.ghy = {1'b0, entry_i.hh} + {1'b0, hy_i};
      s0_in.cx  = entry_i.cx;
      s0_in.cy  = entry_i.cy;
      s0_in.idx = idx_i;
      lox = 34'(entry_i.cx) - $signed({2'b00, s0_in.ghx});
      hix = 34'(entry_i.cx) + $signed({2'b00, s0_in.ghx});
      loy = 34'(entry_i.cy) - $signed({2'b00, s0_in.ghy});
      hiy = 34'(entry_i.cy) + $signed({2'b00, s0_in.ghy});
      dlx_in = DIFF_W'(lox) - DIFF_W'(px_i);
      dhx_in = DIFF_W'(hix) - DIFF_W'(px_i);
      dly_in = DIFF_W'(loy) - DIFF_W'(py_i);
      dhy_in = DIFF_W'(hiy) - DIFF_W'(py_i);
      inx = (34'(px_i) > lox) && (34'(px_i) < hix);
      iny = (34'(py_i) > loy) && (34'(py_i) < hiy);
      s0_in.zfail = ((mx_i == 0) && !inx) || ((my_i == 0) && !iny);
      s0_in.slot = slot_i;
      s0_in.slot.consider = slot_i.consider && ((mask_i & entry_i.layer) != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.slot.valid <= 1'b0;
      end else begin
         s0_ff.slot.valid <= s0_in.slot.valid;
      end
      s0_ff.slot.consider <= s0_in.slot.consider;
      s0_ff.slot.last     <= s0_in.slot.last;
      s0_ff.zfail <= s0_in.zfail;
      s0_ff.cx    <= s0_in.cx;
      s0_ff.cy    <= s0_in.cy;
      s0_ff.ghx   <= s0_in.ghx;
      s0_ff.ghy   <= s0_in.ghy;
      s0_ff.idx   <= s0_in.idx;
      dlx_ff <= dlx_in;
      dhx_ff <= dhx_in;
      dly_ff <= dly_in;
      dhy_ff <= dhy_in;
   end

   // slab times
   logic signed [31:0] qlx, qhx, qly, qhy;

   sbcq_div u_div_lx (.clock(clock), .num_i($signed(64'(dlx_ff)) <<< FRAC_BITS),
                      .den_i(mx_i), .q_o(qlx));
   sbcq_div u_div_hx (.clock(clock), .num_i($signed(64'(dhx_ff)) <<< FRAC_BITS),
                      .den_i(mx_i), .q_o(qhx));
   sbcq_div u_div_ly (.clock(clock), .num_i($signed(64'(dly_ff)) <<< FRAC_BITS),
                      .den_i(my_i), .q_o(qly));
   sbcq_div u_div_hy (.clock(clock), .num_i($signed(64'(dhy_ff)) <<< FRAC_BITS),
                      .den_i(my_i), .q_o(qhy));

   side_type dl_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            dl_ff[i].slot.valid <= 1'b0;
         end
      end else begin
         dl_ff[0].slot.valid <= s0_ff.slot.valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            dl_ff[i].slot.valid <= dl_ff[i-1].slot.valid;
         end
      end
      dl_ff[0].slot.consider <= s0_ff.slot.consider;
      dl_ff[0].slot.last     <= s0_ff.slot.last;
      dl_ff[0].zfail <= s0_ff.zfail;
      dl_ff[0].cx    <= s0_ff.cx;
      dl_ff[0].cy    <= s0_ff.cy;
      dl_ff[0].ghx   <= s0_ff.ghx;
      dl_ff[0].ghy   <= s0_ff.ghy;
      dl_ff[0].idx   <= s0_ff.idx;
      for (int i = 1; i < DIV_LAT; i++) begin
         dl_ff[i].slot.consider <= dl_ff[i-1].slot.consider;
         dl_ff[i].slot.last     <= dl_ff[i-1].slot.last;
         dl_ff[i].zfail <= dl_ff[i-1].zfail;
         dl_ff[i].cx    <= dl_ff[i-1].cx;
         dl_ff[i].cy    <= dl_ff[i-1].cy;
         dl_ff[i].ghx   <= dl_ff[i-1].ghx;
         dl_ff[i].ghy   <= dl_ff[i-1].ghy;
         dl_ff[i].idx   <= dl_ff[i-1].idx;
      end
   end

   // stage 2: entry/exit and hit test
   side_type           s2_ff;
   logic               ok2_ff, ok2_in;
   logic signed [31:0] t2_ff, t2_in;

   always_comb begin
      logic signed [31:0] tnx, tfx, tny, tfy, ext;
      tnx = (qlx < qhx) ? qlx : qhx;
      tfx = (qlx < qhx) ? qhx : qlx;
      tny = (qly < qhy) ? qly : qhy;
      tfy = (qly < qhy) ? qhy : qly;
      t2_in = Q_MIN;
      ext   = Q_MAX;
      if (mx_i != 0) begin
         if (tnx > t2_in) t2_in = tnx;
         if (tfx < ext) ext = tfx;
      end
      if (my_i != 0) begin
         if (tny > t2_in) t2_in = tny;
         if (tfy < ext) ext = tfy;
      end
      ok2_in = dl_ff[DIV_LAT-1].slot.consider && !dl_ff[DIV_LAT-1].zfail &&
               (ext > t2_in) && (ext > 0) && (t2_in < ONE);
   end

   // stage 3: displacement products
   side_type           s3_ff;
   logic               ok3_ff;
   logic signed [31:0] t3_ff;
   logic signed [63:0] prx_ff, pry_ff;

   // stage 4: contact point
   side_type           s4_ff;
   logic               ok4_ff;
   logic signed [31:0] t4_ff, pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [32:0] dx_ff, dy_ff;

   always_comb begin
      pos_x_in = sat32(64'(px_i) + (prx_ff >>> FRAC_BITS));
      pos_y_in = sat32(64'(py_i) + (pry_ff >>> FRAC_BITS));
   end

   // stage 5: normal
   side_type s5_ff;
   hit_type  hit_ff, hit_in;

   always_comb begin
      logic signed [34:0] penx, peny;
      logic signed [32:0] ax, ay;
      ax = dx_ff[32] ? -dx_ff : dx_ff;
      ay = dy_ff[32] ? -dy_ff : dy_ff;
      penx = $signed({3'b000, s4_ff.ghx}) - 35'(ax);
      peny = $signed({3'b000, s4_ff.ghy}) - 35'(ay);
      hit_in.ok = ok4_ff;
      hit_in.t  = t4_ff;
      hit_in.x  = pos_x_ff;
      hit_in.y  = pos_y_ff;
      hit_in.nx = 2'sd0;
      hit_in.ny = 2'sd0;
      if (penx < peny) hit_in.nx = sgn2(dx_ff);
      else hit_in.ny = sgn2(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.slot.valid <= 1'b0;
         s3_ff.slot.valid <= 1'b0;
         s4_ff.slot.valid <= 1'b0;
         s5_ff.slot.valid <= 1'b0;
      end else begin
         s2_ff.slot.valid <= dl_ff[DIV_LAT-1].slot.valid;
         s3_ff.slot.valid <= s2_ff.slot.valid;
         s4_ff.slot.valid <= s3_ff.slot.valid;
         s5_ff.slot.valid <= s4_ff.slot.valid;
      end
      s2_ff.slot.consider <= dl_ff[DIV_LAT-1].slot.consider;
      s2_ff.slot.last     <= dl_ff[DIV_LAT-1].slot.last;
      s2_ff.zfail <= dl_ff[DIV_LAT-1].zfail;
      s2_ff.cx    <= dl_ff[DIV_LAT-1].cx;
      s2_ff.cy    <= dl_ff[DIV_LAT-1].cy;
      s2_ff.ghx   <= dl_ff[DIV_LAT-1].ghx;
      s2_ff.ghy   <= dl_ff[DIV_LAT-1].ghy;
      s2_ff.idx   <= dl_ff[DIV_LAT-1].idx;
      ok2_ff <= ok2_in;
      t2_ff  <= t2_in;

      s3_ff.slot.consider <= s2_ff.slot.consider;
      s3_ff.slot.last     <= s2_ff.slot.last;
      s3_ff.zfail <= s2_ff.zfail;
      s3_ff.cx    <= s2_ff.cx;
      s3_ff.cy    <= s2_ff.cy;
      s3_ff.ghx   <= s2_ff.ghx;
      s3_ff.ghy   <= s2_ff.ghy;
      s3_ff.idx   <= s2_ff.idx;
      ok3_ff <= ok2_ff;
      t3_ff  <= t2_ff;
      prx_ff <= 64'(mx_i) * 64'(t2_ff);
      pry_ff <= 64'(my_i) * 64'(t2_ff);

      s4_ff.slot.consider <= s3_ff.slot.consider;
      s4_ff.slot.last     <= s3_ff.slot.last;
      s4_ff.zfail <= s3_ff.zfail;
      s4_ff.cx    <= s3_ff.cx;
      s4_ff.cy    <= s3_ff.cy;
      s4_ff.ghx   <= s3_ff.ghx;
      s4_ff.ghy   <= s3_ff.ghy;
      s4_ff.idx   <= s3_ff.idx;
      ok4_ff   <= ok3_ff;
      t4_ff    <= t3_ff;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      dx_ff    <= 33'(pos_x_in) - 33'(s3_ff.cx);
      dy_ff    <= 33'(pos_y_in) - 33'(s3_ff.cy);

      s5_ff.slot.consider <= s4_ff.slot.consider;
      s5_ff.slot.last     <= s4_ff.slot.last;
      s5_ff.zfail <= s4_ff.zfail;
      s5_ff.cx    <= s4_ff.cx;
      s5_ff.cy    <= s4_ff.cy;
      s5_ff.ghx   <= s4_ff.ghx;
      s5_ff.ghy   <= s4_ff.ghy;
      s5_ff.idx   <= s4_ff.idx;
      hit_ff <= hit_in;
   end

   assign slot_o = s5_ff.slot;
   assign idx_o  = s5_ff.idx;
   assign hit_o  = hit_ff;

endmodule

>>> rtl/core/swept_box_collision_query_top.sv
// Write transfer: no result.
// Query: from the req transfer to rsp_tvalid, the result passes the one-entry-per-cycle table
// scan and the slab divider pipeline.
// Throughput: one query at a time; the next req transfer waits for the rsp transfer.
// Reset (synchronous, active high) clears box_count, the sequencer and the valid bits;
// table contents stay undefined until written.
module swept_box_collision_query_top #(
   parameter int MAX_BOXES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [6:0]                   csr_wdata,     // box_count
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // entry_index[5:0] center_x[37:6] center_y[69:38] half_width[100:70]
   // half_height[131:101] layer_bits[139:132] mask_bits[147:140]
   // move_x[179:148] move_y[211:180], zero fill above
   input  logic [sbcq_pkg::REQ_W-1:0]   req_tdata,
   input  logic                         req_tuser,     // cmd
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // hit_time[31:0] hit_x[63:32] hit_y[95:64] normal_x[97:96] normal_y[99:98]
   // hit_entry[105:100], zero fill above
   output logic [sbcq_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tuser      // hit
);
   import sbcq_pkg::*;

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   state_type state_ff, state_in;

   logic [6:0]         box_count_ff;
   logic signed [31:0] qpx_ff, qpy_ff, qmx_ff, qmy_ff;
   logic [30:0]        qhx_ff, qhy_ff;
   logic [7:0]         qmask_ff;
   logic               dom_x_ff, dom_y_ff;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   slot_type           slot_ff, slot_in;
   logic [IDX_W-1:0]   slot_idx_ff;

   logic      req_xfer, is_query, issue_last, done;
   entry_type wr_entry, rd_entry;
   logic      wr_en;
   logic [31:0] amx, amy;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_tvalid;
   assign req_xfer   = req_tvalid && req_tready;
   assign is_query   = (cmd_type'(req_tuser) == CMD_QUERY);

   assign wr_entry.cx    = req_tdata[37:6];
   assign wr_entry.cy    = req_tdata[69:38];
   assign wr_entry.hw    = req_tdata[100:70];
   assign wr_entry.hh    = req_tdata[131:101];
   assign wr_entry.layer = req_tdata[139:132];
   assign wr_en = req_xfer && !is_query && (32'(req_tdata[5:0]) < MAX_BOXES);

   sbcq_table #(.MAX_BOXES(MAX_BOXES)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_tdata[5:0])),
      .wr_data (wr_entry),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   always_comb begin
      if (32'(box_count_ff) > MAX_BOXES) n_in = CNT_W'(MAX_BOXES);
      else n_in = CNT_W'(box_count_ff);
      amx = req_tdata[179] ? 32'(-$signed(req_tdata[179:148])) : req_tdata[179:148];
      amy = req_tdata[211] ? 32'(-$signed(req_tdata[211:180])) : req_tdata[211:180];
   end

   always_comb begin
      issue_last = (n_ff == '0) || (scan_ff == n_ff - CNT_W'(1));
      slot_in.valid    = (state_ff == ST_SCAN);
      slot_in.consider = (n_ff != '0);
      slot_in.last     = issue_last;
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_xfer && is_query) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            scan_in = scan_ff + CNT_W'(1);
            if (issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         box_count_ff  <= '0;
         slot_ff.valid <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         slot_ff.valid <= slot_in.valid;
         scan_ff       <= scan_in;
         if (csr_we) box_count_ff <= csr_wdata;
      end
      slot_ff.consider <= slot_in.consider;
      slot_ff.last     <= slot_in.last;
      slot_idx_ff      <= scan_ff[IDX_W-1:0];
      if (req_xfer && is_query) begin
         qpx_ff   <= req_tdata[37:6];
         qpy_ff   <= req_tdata[69:38];
         qhx_ff   <= req_tdata[100:70];
         qhy_ff   <= req_tdata[131:101];
         qmask_ff <= req_tdata[147:140];
         qmx_ff   <= req_tdata[179:148];
         qmy_ff   <= req_tdata[211:180];
         dom_x_ff <= amx > amy;
         dom_y_ff <= amy > amx;
         n_ff     <= n_in;
      end
   end

   slot_type         t_slot;
   logic [IDX_W-1:0] t_idx;
   hit_type          t_hit;

   sbcq_tester #(.MAX_BOXES(MAX_BOXES), .FRAC_BITS(FRAC_BITS)) u_tester (
      .clock   (clock),
      .reset   (reset),
      .slot_i  (slot_ff),
      .idx_i   (slot_idx_ff),
      .entry_i (rd_entry),
      .px_i    (qpx_ff),
      .py_i    (qpy_ff),
      .hx_i    (qhx_ff),
      .hy_i    (qhy_ff),
      .mx_i    (qmx_ff),
      .my_i    (qmy_ff),
      .mask_i  (qmask_ff),
      .slot_o  (t_slot),
      .idx_o   (t_idx),
      .hit_o   (t_hit)
   );

   // running best hit
   hit_type          best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_hit_ff;

   assign done = t_slot.valid && t_slot.last;

   always_comb begin
      logic take, tie;
      tie  = (dom_x_ff && (t_hit.nx != 2'sd0)) || (dom_y_ff && (t_hit.ny != 2'sd0));
      take = t_slot.valid && t_hit.ok &&
             (!best_ff.ok || (t_hit.t < best_ff.t) || ((t_hit.t == best_ff.t) && tie));
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (take) begin
         best_in     = t_hit;
         best_idx_in = t_idx;
      end
      rsp_valid_in = rsp_valid_ff;
      if (done) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.ok   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer && is_query) best_ff.ok <= 1'b0;
         else best_ff.ok <= best_in.ok;
      end
      best_ff.t   <= best_in.t;
      best_ff.x   <= best_in.x;
      best_ff.y   <= best_in.y;
      best_ff.nx  <= best_in.nx;
      best_ff.ny  <= best_in.ny;
      best_idx_ff <= best_idx_in;
      if (done) begin
         rsp_hit_ff <= best_in.ok;
         if (best_in.ok) begin
            rsp_data_ff <= {6'd0, 6'(best_idx_in), best_in.ny, best_in.nx,
                            best_in.y, best_in.x, best_in.t};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef SYNTHESIS
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == ST_DRAIN))
      else $error("scan end seen outside drain");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !rsp_valid_ff)
      else $error("result loaded over a pending transfer");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(scan_ff) < MAX_BOXES))
      else $error("scan index out of table");

   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !issue_last) |=> (state_ff == ST_SCAN))
      else $error("scan left early");
`endif

endmodule
